// ----- sv/b2da_pkg.sv -----
// Shared types and constants for the binary to decimal ASCII converter.
// Used by the digit cell, the top level and the port checker.
package b2da_pkg;

  localparam int VALUE_BITS  = 64;
  localparam int MAX_DIGITS  = 20;
  localparam int DIGIT_W     = 4;
  localparam int CHAR_W      = 6;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 8;
  localparam int BIT_CNT_W   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);

  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO   = 6'd48;
  localparam logic [CHAR_W-1:0]  ASCII_NINE   = 6'd57;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_DIGITS
  } state_t;

  // Per-cycle command shared by every digit cell in the chain.
  typedef struct packed {
    logic clear;
    logic dabble;
    logic advance;
  } cell_ctrl_t;

endpackage

// ----- sv/b2da_cell.sv -----
// One BCD digit cell of the double dabble chain.
// Depends on b2da_pkg for the digit width and the cell command struct.
module b2da_cell (
  input  logic                         clk,
  input  b2da_pkg::cell_ctrl_t         ctrl,
  input  logic                         bit_in,
  input  logic [b2da_pkg::DIGIT_W-1:0] digit_in,
  output logic                         bit_out,
  output logic [b2da_pkg::DIGIT_W-1:0] digit
);
  import b2da_pkg::*;

  logic [DIGIT_W-1:0] adj;
  logic [DIGIT_W-1:0] digit_next;

  // Add three to any digit of five or more so the following left shift carries correctly.
  assign adj     = (digit >= DABBLE_LIMIT) ? digit + DABBLE_ADD : digit;
  assign bit_out = adj[DIGIT_W-1];

  always_comb begin
    if (ctrl.clear) begin
      digit_next = '0;
    end else if (ctrl.dabble) begin
      digit_next = {adj[DIGIT_W-2:0], bit_in};
    end else if (ctrl.advance) begin
      digit_next = digit_in;
    end else begin
      digit_next = digit;
    end
  end

  always_ff @(posedge clk) begin
    digit <= digit_next;
  end

endmodule

// ----- sv/binary_to_decimal_ascii_unit.sv -----
// The first character is registered after the accept step, the conversion and the skipping
// of leading zeros; one more character per cycle follows while m_tready is held high.
// A new value is taken only from idle, so one value at a time passes: an accept step,
// one shift-add-3 step per input bit through the digit cell chain, then 20 digit slots.
// Reset (rst, synchronous) returns the controller to idle and drops the output valid.
module binary_to_decimal_ascii_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [b2da_pkg::IN_TDATA_W-1:0]  s_tdata,   // [63:0] value
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [b2da_pkg::OUT_TDATA_W-1:0] m_tdata,   // [5:0] digit_char, [7:6] zero
  output logic                             m_tlast
);
  import b2da_pkg::*;

  state_t                 state;
  state_t                 state_next;
  cell_ctrl_t             ctrl;
  logic [VALUE_BITS-1:0]  value_sr;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic [DIGIT_CNT_W-1:0] remaining;
  logic                   leading;
  logic                   load_out;
  logic                   accept;
  logic [CHAR_W-1:0]      m_char;
  logic [DIGIT_W-1:0]     top_digit;
  logic                   carry [MAX_DIGITS+1];
  logic [DIGIT_W-1:0]     digits [MAX_DIGITS];

  assign carry[0]  = value_sr[VALUE_BITS-1];
  assign top_digit = digits[MAX_DIGITS-1];
  assign accept    = s_tvalid && s_tready;

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    logic [DIGIT_W-1:0] link;
    if (i == 0) begin : g_first
      assign link = '0;
    end else begin : g_rest
      assign link = digits[i-1];
    end
    b2da_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .bit_in   (carry[i]),
      .digit_in (link),
      .bit_out  (carry[i+1]),
      .digit    (digits[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    s_tready   = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctrl.clear = 1'b1;
          state_next = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        ctrl.dabble = 1'b1;
        if (bit_cnt == BIT_CNT_W'(VALUE_BITS - 1)) begin
          state_next = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        // Leading zeros are rotated out of the top cell without output; the last digit
        // always goes out so that zero gives a single character.
        if (leading && top_digit == '0 && remaining != DIGIT_CNT_W'(1)) begin
          ctrl.advance = 1'b1;
        end else if (!m_tvalid || m_tready) begin
          ctrl.advance = 1'b1;
          load_out     = 1'b1;
          if (remaining == DIGIT_CNT_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_sr <= s_tdata[VALUE_BITS-1:0];
    end else if (ctrl.dabble) begin
      value_sr <= value_sr << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt   <= '0;
      remaining <= '0;
      leading   <= 1'b0;
    end else begin
      if (accept) begin
        bit_cnt <= '0;
      end else if (ctrl.dabble) begin
        bit_cnt <= bit_cnt + BIT_CNT_W'(1);
      end
      if (accept) begin
        remaining <= DIGIT_CNT_W'(MAX_DIGITS);
      end else if (ctrl.advance) begin
        remaining <= remaining - DIGIT_CNT_W'(1);
      end
      if (accept) begin
        leading <= 1'b1;
      end else if (load_out) begin
        leading <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_char  <= ASCII_ZERO + CHAR_W'(top_digit);
      m_tlast <= (remaining == DIGIT_CNT_W'(1));
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - CHAR_W){1'b0}}, m_char};

endmodule

// ----- sv/b2da_checker.sv -----
// Port-level checks for binary_to_decimal_ascii_unit, attached by a bind statement.
// Depends on b2da_pkg for the port widths and the ASCII digit bounds.
module b2da_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [b2da_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                             m_tlast
);
  import b2da_pkg::*;

  // A stalled output transaction keeps its character and end flag.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[CHAR_W-1:0] >= ASCII_ZERO && m_tdata[CHAR_W-1:0] <= ASCII_NINE
                 && m_tdata[OUT_TDATA_W-1:CHAR_W] == '0)
    else $error("output character is not a decimal digit");

  // One value at a time: the input closes right after a transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a transaction");

  // The output valid drops right after the last character of a run is taken.
  a_quiet_after_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid)
    else $error("character emitted after the end of a run");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind binary_to_decimal_ascii_unit b2da_checker u_b2da_checker (.*);
